// File: rtl/core/rectangle_point_cover_count_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle point cover count block
// Checks are compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RECTANGLE_POINT_COVER_COUNT_TOP_ASSERT_SVH
`define RECTANGLE_POINT_COVER_COUNT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define RPCC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpcc check failed");

// cons must hold starting in the cycle after ante
`define RPCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpcc check failed");

`else

`define RPCC_ASSERT_SAME(lbl, ante, cons)
`define RPCC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/rpcc_pkg.sv
// ---------------------------------------------------------------------------
// rpcc_pkg
// Shared constants and request codes for the rectangle point cover count.
// ---------------------------------------------------------------------------
package rpcc_pkg;

	localparam int MAX_RECTS = 16;
	localparam int COORD_W   = 32;
	localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int TOTAL_W   = $clog2(MAX_RECTS + 1);
	localparam int SUM_W     = $clog2(MAX_RECTS + 1);

	localparam int COUNT_W   = 5;
	localparam int COUNT_MAX = 31;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

endpackage

// File: rtl/core/rectangle_point_cover_count_top.sv
// ---------------------------------------------------------------------------
// rectangle_point_cover_count_top
// Rectangle table with point queries that count covering rectangles.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with req_type and its operands; the word is taken at that
//   edge since busy is always low. Load appends a half-open rectangle
//   (left <= x < right, bottom <= y < top, signed), query counts stored
//   rectangles covering (point_x, point_y), clear empties the table.
//   A load into a full table is dropped and answered with status 1.
//   Every request gives one result word: done pulses for one cycle with
//   cover_count and status. The receiver cannot hold results off.
//   The input register and then the result register lie between the accepting
//   edge and done. One request per cycle is sustained. The table is updated
//   from the input register, and queries compare there against all entries
//   at once, so a query right after a load or clear already sees it.
//   Stages: input register, then compare of every entry, popcount and
//   saturation into the result register.
//   Reset empties the table and drops any words in flight; table contents
//   are not cleared, only the fill count.
// ---------------------------------------------------------------------------
`include "rectangle_point_cover_count_top_assert.svh"

module rectangle_point_cover_count_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          req_type,
	input  logic signed [rpcc_pkg::COORD_W-1:0] rect_left,
	input  logic signed [rpcc_pkg::COORD_W-1:0] rect_bottom,
	input  logic signed [rpcc_pkg::COORD_W-1:0] rect_right,
	input  logic signed [rpcc_pkg::COORD_W-1:0] rect_top,
	input  logic signed [rpcc_pkg::COORD_W-1:0] point_x,
	input  logic signed [rpcc_pkg::COORD_W-1:0] point_y,
	output logic                                done,
	output logic [rpcc_pkg::COUNT_W-1:0]        cover_count,
	output logic                                status
);

	// input stage
	logic                                vld_s1;
	logic [1:0]                          req_s1;
	logic signed [rpcc_pkg::COORD_W-1:0] left_s1, bottom_s1, right_s1, top_s1;
	logic signed [rpcc_pkg::COORD_W-1:0] px_s1, py_s1;

	// rectangle table
	logic signed [rpcc_pkg::COORD_W-1:0] left_q   [rpcc_pkg::MAX_RECTS];
	logic signed [rpcc_pkg::COORD_W-1:0] bottom_q [rpcc_pkg::MAX_RECTS];
	logic signed [rpcc_pkg::COORD_W-1:0] right_q  [rpcc_pkg::MAX_RECTS];
	logic signed [rpcc_pkg::COORD_W-1:0] top_q    [rpcc_pkg::MAX_RECTS];
	logic [rpcc_pkg::TOTAL_W-1:0]        total_q;

	logic                                full;
	logic                                load_s1, clear_s1, query_s1, write_s1;
	logic [rpcc_pkg::MAX_RECTS-1:0]      hit;

	// result
	logic [rpcc_pkg::SUM_W-1:0]          sum;
	logic [rpcc_pkg::COUNT_W-1:0]        count_sat;
	logic                                done_q, status_q;
	logic [rpcc_pkg::COUNT_W-1:0]        count_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1    <= req_type;
			left_s1   <= rect_left;
			bottom_s1 <= rect_bottom;
			right_s1  <= rect_right;
			top_s1    <= rect_top;
			px_s1     <= point_x;
			py_s1     <= point_y;
		end
	end

	assign full     = (total_q >= rpcc_pkg::TOTAL_W'(rpcc_pkg::MAX_RECTS));
	assign load_s1  = vld_s1 && (req_s1 == rpcc_pkg::REQ_LOAD);
	assign query_s1 = vld_s1 && (req_s1 == rpcc_pkg::REQ_QUERY);
	assign clear_s1 = vld_s1 && (req_s1 == rpcc_pkg::REQ_CLEAR);
	assign write_s1 = load_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (clear_s1) begin
			total_q <= '0;
		end else if (write_s1) begin
			total_q <= total_q + rpcc_pkg::TOTAL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (write_s1) begin
			left_q[total_q[rpcc_pkg::IDX_W-1:0]]   <= left_s1;
			bottom_q[total_q[rpcc_pkg::IDX_W-1:0]] <= bottom_s1;
			right_q[total_q[rpcc_pkg::IDX_W-1:0]]  <= right_s1;
			top_q[total_q[rpcc_pkg::IDX_W-1:0]]    <= top_s1;
		end
	end

	// one comparator lane per table entry; entries past the fill count never hit
	always_comb begin
		for (int k = 0; k < rpcc_pkg::MAX_RECTS; k++) begin
			hit[k] = query_s1 && (rpcc_pkg::TOTAL_W'(k) < total_q)
				&& (left_q[k] <= px_s1) && (px_s1 < right_q[k])
				&& (bottom_q[k] <= py_s1) && (py_s1 < top_q[k]);
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < rpcc_pkg::MAX_RECTS; k++) begin
			sum = sum + rpcc_pkg::SUM_W'(hit[k]);
		end
		if (int'(sum) > rpcc_pkg::COUNT_MAX) begin
			count_sat = rpcc_pkg::COUNT_W'(rpcc_pkg::COUNT_MAX);
		end else begin
			count_sat = rpcc_pkg::COUNT_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		count_q  <= count_sat;
		status_q <= load_s1 && full;
	end

	assign done        = done_q;
	assign cover_count = count_q;
	assign status      = status_q;

	`RPCC_ASSERT_SAME(a_total_bound, 1'b1, total_q <= rpcc_pkg::TOTAL_W'(rpcc_pkg::MAX_RECTS))
	`RPCC_ASSERT_NEXT(a_clear_empties, clear_s1, total_q == '0)
	`RPCC_ASSERT_NEXT(a_latency, start && !busy, ##1 done)
	`RPCC_ASSERT_SAME(a_drop_no_count, done && status, cover_count == '0)

endmodule
